/* rtl/thc_pkg.sv */
// ----------------------------------------------------------------------------
// thc_pkg
// Shared types and constants of the tilt-compensated heading core.
// ----------------------------------------------------------------------------
package thc_pkg;

  // Fixed-point formats
  localparam int Q_BITS      = 30;             // sines and cosines, 1.0 = 2^30
  localparam int ROOT_W      = Q_BITS + 1;     // floor square root of a value <= 2^60
  localparam int RAD_W       = 2 * ROOT_W;     // radicand width
  localparam int XY_W        = 52;             // horizontal field components
  localparam int Z_W         = 33;             // angle accumulator, 2^-22 degree
  localparam int HEADING_W   = 15;
  localparam int HEADING_SHIFT = 16;           // 2^-22 degree down to 1/64 degree
  localparam int HEADING_LIMIT = 23040;        // 360 degrees in 1/64 degree
  localparam int TABLE_LEN   = 24;

  localparam longint ANG_DEG = 64'sd4194304;   // one degree in accumulator units
  localparam longint ANG_180 = 180 * ANG_DEG;
  localparam longint ANG_360 = 360 * ANG_DEG;

  // atan(2^-i) in nano-degrees
  localparam longint ATAN_NDEG [TABLE_LEN] = '{
    64'sd45000000000, 64'sd26565051177, 64'sd14036243468, 64'sd7125016349,
    64'sd3576334375,  64'sd1789910608,  64'sd895173710,   64'sd447614171,
    64'sd223810500,   64'sd111905677,   64'sd55952892,    64'sd27976453,
    64'sd13988227,    64'sd6994114,     64'sd3497057,     64'sd1748528,
    64'sd874264,      64'sd437132,      64'sd218566,      64'sd109283,
    64'sd54642,       64'sd27321,       64'sd13660,       64'sd6830
  };

  // Angle table entry in accumulator units, rounded
  function automatic longint atan_unit(input int unsigned idx);
    return (ATAN_NDEG[idx] * ANG_DEG + 64'sd500000000) / 64'sd1000000000;
  endfunction

  // Input transfer
  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
  } sample_t;

  // Result transfer
  typedef struct packed {
    logic [HEADING_W-1:0] heading;
    logic                 tilt_saturated;
  } result_t;

  // Carried alongside the pitch cosine root
  typedef struct packed {
    logic signed [31:0] sp;
    logic signed [15:0] ay;
    logic signed [15:0] mx;
    logic signed [15:0] my;
    logic signed [15:0] mz;
    logic               sat;
  } side1_t;

  // One stage of the roll sine divider
  typedef struct packed {
    logic [ROOT_W-1:0]  cp;
    logic [ROOT_W-1:0]  rem;
    logic [ROOT_W-1:0]  quo;
    logic               lsb;
    logic               clamp;
    logic               azero;
    logic               ay_neg;
    logic               sat;
    logic signed [31:0] sp;
    logic signed [15:0] mx;
    logic signed [15:0] my;
    logic signed [15:0] mz;
  } div_t;

  // Carried alongside the roll cosine root
  typedef struct packed {
    logic signed [31:0] sr;
    logic signed [31:0] sp;
    logic [ROOT_W-1:0]  cp;
    logic signed [15:0] mx;
    logic signed [15:0] my;
    logic signed [15:0] mz;
    logic               sat;
  } side2_t;

endpackage

/* rtl/thc_isqrt.sv */
// ----------------------------------------------------------------------------
// thc_isqrt
// Pipelined floor square root, one root bit per stage, with a sideband.
// ----------------------------------------------------------------------------
module thc_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [thc_pkg::RAD_W-1:0]   rad_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        valid_o,
  output logic [thc_pkg::ROOT_W-1:0]  root_o,
  output logic [SIDE_W-1:0]           side_o
);

  localparam int STEPS = thc_pkg::ROOT_W;
  localparam int RAD_W = thc_pkg::RAD_W;
  localparam int REM_W = thc_pkg::ROOT_W + 2;

  logic              vld_q  [STEPS];
  logic [RAD_W-1:0]  rad_q  [STEPS];
  logic [REM_W-1:0]  rem_q  [STEPS];
  logic [STEPS-1:0]  root_q [STEPS];
  logic [SIDE_W-1:0] side_q [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic              vld_in;
    logic [RAD_W-1:0]  rad_in;
    logic [REM_W-1:0]  rem_in;
    logic [STEPS-1:0]  root_in;
    logic [SIDE_W-1:0] side_in;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic              take;

    // Select the previous stage or the input
    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    // Bring down two radicand bits and try the next root bit
    assign rem_sh = {rem_in, rad_in[RAD_W-1 -: 2]};
    assign trial  = (REM_W+2)'({root_in, 2'b01});
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[k]  <= {rad_in[RAD_W-3:0], 2'b00};
      rem_q[k]  <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root_q[k] <= {root_in[STEPS-2:0], take};
      side_q[k] <= side_in;
    end
  end

  assign valid_o = vld_q[STEPS-1];
  assign root_o  = root_q[STEPS-1];
  assign side_o  = side_q[STEPS-1];

endmodule

/* rtl/thc_cordic.sv */
// ----------------------------------------------------------------------------
// thc_cordic
// Pipelined CORDIC vectoring: atan2 of the horizontal field in 1/64 degree.
// ----------------------------------------------------------------------------
module thc_cordic #(
  parameter int STEPS  = 16,
  parameter int SIDE_W = 1
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  logic signed [thc_pkg::XY_W-1:0]      x_i,
  input  logic signed [thc_pkg::XY_W-1:0]      y_i,
  input  logic [SIDE_W-1:0]                    side_i,
  output logic                                 valid_o,
  output logic [thc_pkg::HEADING_W-1:0]        heading_o,
  output logic [SIDE_W-1:0]                    side_o
);

  localparam int XY_W = thc_pkg::XY_W;
  localparam int Z_W  = thc_pkg::Z_W;

  logic                   vld_q  [STEPS+1];
  logic signed [XY_W-1:0] x_q    [STEPS+1];
  logic signed [XY_W-1:0] y_q    [STEPS+1];
  logic signed [Z_W-1:0]  z_q    [STEPS+1];
  logic                   zero_q [STEPS+1];
  logic [SIDE_W-1:0]      side_q [STEPS+1];

  // Fold the left half-plane by 180 degrees
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q[0] <= (x_i == '0) && (y_i == '0);
    side_q[0] <= side_i;
    if (x_i < 0) begin
      x_q[0] <= -x_i;
      y_q[0] <= -y_i;
      z_q[0] <= Z_W'(thc_pkg::ANG_180);
    end else begin
      x_q[0] <= x_i;
      y_q[0] <= y_i;
      z_q[0] <= '0;
    end
  end

  // Rotate toward the x axis, one micro-rotation per stage
  for (genvar k = 1; k <= STEPS; k++) begin : g_iter
    localparam logic signed [Z_W-1:0] ATAN_K = Z_W'(thc_pkg::atan_unit(k-1));
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;

    assign dx = y_q[k-1] >>> (k-1);
    assign dy = x_q[k-1] >>> (k-1);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      zero_q[k] <= zero_q[k-1];
      side_q[k] <= side_q[k-1];
      if (y_q[k-1] > 0) begin
        x_q[k] <= x_q[k-1] + dx;
        y_q[k] <= y_q[k-1] - dy;
        z_q[k] <= z_q[k-1] + ATAN_K;
      end else begin
        x_q[k] <= x_q[k-1] - dx;
        y_q[k] <= y_q[k-1] + dy;
        z_q[k] <= z_q[k-1] - ATAN_K;
      end
    end
  end

  // Wrap to one turn and drop to 1/64 degree
  logic signed [Z_W-1:0]            z_wrap;
  logic                             valid_q;
  logic [thc_pkg::HEADING_W-1:0]    heading_q;
  logic [SIDE_W-1:0]                side_out_q;

  always_comb begin
    if (z_q[STEPS] < 0) begin
      z_wrap = z_q[STEPS] + Z_W'(thc_pkg::ANG_360);
    end else if (z_q[STEPS] >= Z_W'(thc_pkg::ANG_360)) begin
      z_wrap = z_q[STEPS] - Z_W'(thc_pkg::ANG_360);
    end else begin
      z_wrap = z_q[STEPS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= vld_q[STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    heading_q  <= zero_q[STEPS] ? '0
                : z_wrap[thc_pkg::HEADING_SHIFT +: thc_pkg::HEADING_W];
    side_out_q <= side_q[STEPS];
  end

  assign valid_o   = valid_q;
  assign heading_o = heading_q;
  assign side_o    = side_out_q;

endmodule

/* rtl/tilt_compensated_heading_core.sv */
// ----------------------------------------------------------------------------
// tilt_compensated_heading_core
// Tilt-compensated compass heading from one accelerometer and magnetometer
// sample.
// ----------------------------------------------------------------------------
// A sample is taken in every clock cycle: busy stays low and start may be held
// high continuously. Each sample gives one result on result_o, marked by a
// one-cycle done_o pulse, in order. Each sample passes through a 31-stage
// square root for the pitch cosine, a 31-stage divider for the roll sine, a
// second 31-stage square root for the roll cosine, four multiply and sum
// stages and the CORDIC stages with their fold and wrap steps.
module tilt_compensated_heading_core #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ACCEL_FRAC_BITS = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  thc_pkg::sample_t  sample_i,
  output logic              done_o,
  output thc_pkg::result_t  result_o
);

  localparam int Q_BITS   = thc_pkg::Q_BITS;
  localparam int ROOT_W   = thc_pkg::ROOT_W;
  localparam int RAD_W    = thc_pkg::RAD_W;
  localparam int XY_W     = thc_pkg::XY_W;
  localparam int CORDIC_N = (CORDIC_STEPS < thc_pkg::TABLE_LEN) ?
                            CORDIC_STEPS : thc_pkg::TABLE_LEN;
  localparam int LATENCY  = 3 * ROOT_W + 9 + CORDIC_N;
  localparam int NUM_W    = 48;
  localparam int T_W      = 48;
  localparam int P_W      = 63;

  localparam logic signed [16:0]  ACC_LIM = 17'(longint'(1) << ACCEL_FRAC_BITS);
  localparam logic [RAD_W-1:0]    ONE_2F  = RAD_W'(longint'(1) << (2 * ACCEL_FRAC_BITS));
  localparam logic [RAD_W-1:0]    ONE_60  = RAD_W'(1) << (2 * Q_BITS);
  localparam logic [ROOT_W-1:0]   Q_ONE   = ROOT_W'(1) << Q_BITS;
  localparam logic signed [P_W-1:0] TRUNC_BIAS = P_W'((longint'(1) << Q_BITS) - 1);

  // Every cycle takes a sample
  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // Stage 0: clamp the pitch sine, form the pitch cosine radicand
  // --------------------------------------------------------------------------
  logic signed [16:0] s_raw;
  logic signed [16:0] s_clp;
  logic               s_sat;
  logic [14:0]        s_mag;
  logic [29:0]        s_sq;

  always_comb begin
    s_raw = -(17'(sample_i.accel_x));
    s_sat = 1'b0;
    s_clp = s_raw;
    if (s_raw > ACC_LIM) begin
      s_clp = ACC_LIM;
      s_sat = 1'b1;
    end else if (s_raw < -ACC_LIM) begin
      s_clp = -ACC_LIM;
      s_sat = 1'b1;
    end
    s_mag = (s_clp < 0) ? 15'(-s_clp) : 15'(s_clp);
    s_sq  = 30'(s_mag) * 30'(s_mag);
  end

  logic                  v0_q;
  thc_pkg::side1_t       s0_q;
  logic [RAD_W-1:0]      rad1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q.sp  <= 32'(s_clp) <<< (Q_BITS - ACCEL_FRAC_BITS);
    s0_q.ay  <= sample_i.accel_y;
    s0_q.mx  <= sample_i.mag_x;
    s0_q.my  <= sample_i.mag_y;
    s0_q.mz  <= sample_i.mag_z;
    s0_q.sat <= s_sat;
    rad1_q   <= (ONE_2F - RAD_W'(s_sq)) << (2 * Q_BITS - 2 * ACCEL_FRAC_BITS);
  end

  // --------------------------------------------------------------------------
  // Pitch cosine
  // --------------------------------------------------------------------------
  logic              sq1_vld;
  logic [ROOT_W-1:0] sq1_root;
  thc_pkg::side1_t   sq1_side;

  thc_isqrt #(
    .SIDE_W ($bits(thc_pkg::side1_t))
  ) u_sqrt_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v0_q),
    .rad_i   (rad1_q),
    .side_i  (s0_q),
    .valid_o (sq1_vld),
    .root_o  (sq1_root),
    .side_o  (sq1_side)
  );

  // --------------------------------------------------------------------------
  // Roll sine: compare against the unit limit, then divide one bit a stage
  // --------------------------------------------------------------------------
  logic [16:0]      ay_abs;
  logic [NUM_W-1:0] num;

  assign ay_abs = (sq1_side.ay < 0) ? 17'(-(17'(sq1_side.ay))) : 17'(sq1_side.ay);
  assign num    = NUM_W'(ay_abs) << (Q_BITS - ACCEL_FRAC_BITS);

  logic          dv_q  [ROOT_W+1];
  thc_pkg::div_t div_q [ROOT_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else begin
      dv_q[0] <= sq1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q[0].cp     <= sq1_root;
    div_q[0].rem    <= num[ROOT_W:1];
    div_q[0].quo    <= '0;
    div_q[0].lsb    <= num[0];
    div_q[0].clamp  <= (num > NUM_W'(sq1_root));
    div_q[0].azero  <= (ay_abs == '0);
    div_q[0].ay_neg <= (sq1_side.ay < 0);
    div_q[0].sat    <= sq1_side.sat;
    div_q[0].sp     <= sq1_side.sp;
    div_q[0].mx     <= sq1_side.mx;
    div_q[0].my     <= sq1_side.my;
    div_q[0].mz     <= sq1_side.mz;
  end

  for (genvar k = 1; k <= ROOT_W; k++) begin : g_div
    logic [ROOT_W:0] rem_sh;
    logic            take;
    thc_pkg::div_t   div_d;

    // Shift in the next dividend bit and try a subtract
    assign rem_sh = {div_q[k-1].rem, (k == 1) ? div_q[k-1].lsb : 1'b0};
    assign take   = (rem_sh >= {1'b0, div_q[k-1].cp});

    // Carry the item forward with the new remainder and quotient bit
    always_comb begin
      div_d     = div_q[k-1];
      div_d.rem = take ? ROOT_W'(rem_sh - {1'b0, div_q[k-1].cp}) : ROOT_W'(rem_sh);
      div_d.quo = {div_q[k-1].quo[ROOT_W-2:0], take};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k] <= 1'b0;
      end else begin
        dv_q[k] <= dv_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      div_q[k] <= div_d;
    end
  end

  // --------------------------------------------------------------------------
  // Select the roll sine, form the roll cosine radicand
  // --------------------------------------------------------------------------
  thc_pkg::div_t     dq;
  logic [ROOT_W-1:0] sr_mag;
  logic [RAD_W-1:0]  sr_sq;

  always_comb begin
    dq = div_q[ROOT_W];
    if (dq.clamp) begin
      sr_mag = Q_ONE;
    end else if (dq.azero) begin
      sr_mag = '0;
    end else begin
      sr_mag = dq.quo;
    end
    sr_sq = RAD_W'(sr_mag) * RAD_W'(sr_mag);
  end

  logic             vp_q;
  thc_pkg::side2_t  p_q;
  logic [RAD_W-1:0] rad2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else begin
      vp_q <= dv_q[ROOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    p_q.sr  <= dq.ay_neg ? -$signed({1'b0, sr_mag}) : $signed({1'b0, sr_mag});
    p_q.sp  <= dq.sp;
    p_q.cp  <= dq.cp;
    p_q.mx  <= dq.mx;
    p_q.my  <= dq.my;
    p_q.mz  <= dq.mz;
    p_q.sat <= dq.sat | dq.clamp;
    rad2_q  <= ONE_60 - sr_sq;
  end

  // --------------------------------------------------------------------------
  // Roll cosine
  // --------------------------------------------------------------------------
  logic              sq2_vld;
  logic [ROOT_W-1:0] sq2_root;
  thc_pkg::side2_t   sq2_side;

  thc_isqrt #(
    .SIDE_W ($bits(thc_pkg::side2_t))
  ) u_sqrt_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vp_q),
    .rad_i   (rad2_q),
    .side_i  (p_q),
    .valid_o (sq2_vld),
    .root_o  (sq2_root),
    .side_o  (sq2_side)
  );

  // --------------------------------------------------------------------------
  // Rotate the field into the horizontal plane
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic signed [P_W-1:0] p_sp;
    logic signed [P_W-1:0] p_cp;
    logic signed [T_W-1:0] t_xc;
    logic signed [T_W-1:0] t_xs;
    logic signed [T_W-1:0] t_yc;
    logic signed [15:0]    mx;
    logic signed [15:0]    mz;
    logic                  sat;
  } mul1_t;

  typedef struct packed {
    logic signed [31:0]    q_sp;
    logic signed [31:0]    q_cp;
    logic signed [T_W-1:0] t_xc;
    logic signed [T_W-1:0] t_xs;
    logic signed [T_W-1:0] t_yc;
    logic signed [15:0]    mx;
    logic signed [15:0]    mz;
    logic                  sat;
  } mul2_t;

  typedef struct packed {
    logic signed [T_W-1:0] u_x;
    logic signed [T_W-1:0] u_z;
    logic signed [T_W-1:0] t_xc;
    logic signed [T_W-1:0] t_xs;
    logic signed [T_W-1:0] t_yc;
    logic                  sat;
  } mul3_t;

  logic               cp_s;
  logic signed [31:0] cp_w;
  logic signed [31:0] cr_w;
  logic               vm1_q, vm2_q, vm3_q, vm4_q;
  mul1_t              m1_q;
  mul2_t              m2_q;
  mul3_t              m3_q;
  logic signed [XY_W-1:0] xh_q;
  logic signed [XY_W-1:0] yh_q;
  logic                   sat4_q;

  assign cp_s = 1'b0;
  assign cp_w = $signed({cp_s, sq2_side.cp});
  assign cr_w = $signed({1'b0, sq2_root});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm1_q <= 1'b0;
      vm2_q <= 1'b0;
      vm3_q <= 1'b0;
      vm4_q <= 1'b0;
    end else begin
      vm1_q <= sq2_vld;
      vm2_q <= vm1_q;
      vm3_q <= vm2_q;
      vm4_q <= vm3_q;
    end
  end

  // Multiply the sines and cosines and the direct field terms
  always_ff @(posedge clk_i) begin
    m1_q.p_sp <= P_W'(sq2_side.sr) * P_W'(sq2_side.sp);
    m1_q.p_cp <= P_W'(sq2_side.sr) * P_W'(cp_w);
    m1_q.t_xc <= T_W'(sq2_side.mx) * T_W'(cp_w);
    m1_q.t_xs <= T_W'(sq2_side.mz) * T_W'(sq2_side.sp);
    m1_q.t_yc <= T_W'(sq2_side.my) * T_W'(cr_w);
    m1_q.mx   <= sq2_side.mx;
    m1_q.mz   <= sq2_side.mz;
    m1_q.sat  <= sq2_side.sat;
  end

  // Truncate the Q60 products toward zero back to Q30
  always_ff @(posedge clk_i) begin
    m2_q.q_sp <= m1_q.p_sp[P_W-1] ? 32'((m1_q.p_sp + TRUNC_BIAS) >>> Q_BITS)
                                  : 32'(m1_q.p_sp >>> Q_BITS);
    m2_q.q_cp <= m1_q.p_cp[P_W-1] ? 32'((m1_q.p_cp + TRUNC_BIAS) >>> Q_BITS)
                                  : 32'(m1_q.p_cp >>> Q_BITS);
    m2_q.t_xc <= m1_q.t_xc;
    m2_q.t_xs <= m1_q.t_xs;
    m2_q.t_yc <= m1_q.t_yc;
    m2_q.mx   <= m1_q.mx;
    m2_q.mz   <= m1_q.mz;
    m2_q.sat  <= m1_q.sat;
  end

  // Weight the field by the combined terms
  always_ff @(posedge clk_i) begin
    m3_q.u_x  <= T_W'(m2_q.mx) * T_W'(m2_q.q_sp);
    m3_q.u_z  <= T_W'(m2_q.mz) * T_W'(m2_q.q_cp);
    m3_q.t_xc <= m2_q.t_xc;
    m3_q.t_xs <= m2_q.t_xs;
    m3_q.t_yc <= m2_q.t_yc;
    m3_q.sat  <= m2_q.sat;
  end

  // Sum the horizontal components
  always_ff @(posedge clk_i) begin
    xh_q   <= XY_W'(m3_q.t_xc) + XY_W'(m3_q.t_xs);
    yh_q   <= XY_W'(m3_q.u_x) + XY_W'(m3_q.t_yc) - XY_W'(m3_q.u_z);
    sat4_q <= m3_q.sat;
  end

  // --------------------------------------------------------------------------
  // Heading
  // --------------------------------------------------------------------------
  logic                          hd_vld;
  logic [thc_pkg::HEADING_W-1:0] hd_heading;
  logic                          hd_sat;

  thc_cordic #(
    .STEPS  (CORDIC_N),
    .SIDE_W (1)
  ) u_cordic (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (vm4_q),
    .x_i       (xh_q),
    .y_i       (yh_q),
    .side_i    (sat4_q),
    .valid_o   (hd_vld),
    .heading_o (hd_heading),
    .side_o    (hd_sat)
  );

  assign done_o                  = hd_vld;
  assign result_o.heading        = hd_heading;
  assign result_o.tilt_saturated = hd_sat;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY done_o)
    else $error("result missing after a sample transfer");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LATENCY))
    else $error("result without a matching sample transfer");

  a_heading_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.heading < thc_pkg::HEADING_W'(thc_pkg::HEADING_LIMIT)))
    else $error("heading beyond one turn");

  a_pitch_clamp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && ((-(17'(sample_i.accel_x)) > ACC_LIM) ||
                        (-(17'(sample_i.accel_x)) < -ACC_LIM)))
    |-> ##LATENCY result_o.tilt_saturated)
    else $error("pitch clamp not flagged");

endmodule
